>>> rtl/core/stack_permutation_checker_macros.svh
// Assertion helpers shared by the checker RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STACK_PERMUTATION_CHECKER_MACROS_SVH
`define STACK_PERMUTATION_CHECKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/spc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

  // Width of a car number as carried on the ports.
  localparam int CAR_W = 11;

  // Default capacity of the holding stack.
  localparam int DEF_MAX_CARS = 1024;

  // Highest car number the port can carry.
  localparam int CAR_MAX_CODE = (1 << CAR_W) - 1;

  // Command from the controller to the chain of stack cells.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [CAR_W-1:0] data;
  } spc_cmd_t;

  // Controller status seen by the top level.
  typedef struct packed {
    logic busy;
    logic empty;
  } spc_stat_t;

  // Number of stack cells that can ever be occupied. Pushed cars are always
  // below the wanted car, which is at most min(max_cars, CAR_MAX_CODE).
  function automatic int spc_cells(input int max_cars);
    int lim;
    begin
      lim = (max_cars < CAR_MAX_CODE) ? max_cars : CAR_MAX_CODE;
      return (lim > 1) ? lim - 1 : 1;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/spc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One entry of the shifting stack. A push takes the value from the cell
// nearer the top, a pop takes the value from the cell further down.
module spc_cell
  import spc_pkg::*;
(
  input  wire logic             clk,
  input  var  spc_cmd_t         cmd,
  input  wire logic [CAR_W-1:0] above,
  input  wire logic [CAR_W-1:0] below,
  output      logic [CAR_W-1:0] q
);

  logic [CAR_W-1:0] q_r;
  logic [CAR_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (cmd.push) begin
      q_nxt = above;
    end else if (cmd.pop) begin
      q_nxt = below;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

>>> rtl/core/spc_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Holding stack built as a row of shifting cells. Cell 0 is the top.
module spc_stack
  import spc_pkg::*;
#(
  parameter int MAX_CARS = DEF_MAX_CARS
) (
  input  wire logic             clk,
  input  var  spc_cmd_t         cmd,
  output      logic [CAR_W-1:0] top_car
);

  localparam int NCELLS = spc_cells(MAX_CARS);

  logic [CAR_W-1:0] cell_q [NCELLS];

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    logic [CAR_W-1:0] above;
    logic [CAR_W-1:0] below;

    if (i == 0) begin : g_top
      assign above = cmd.data;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end

    if (i == NCELLS - 1) begin : g_bot
      assign below = cell_q[i];
    end else begin : g_nbot
      assign below = cell_q[i+1];
    end

    spc_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .above (above),
      .below (below),
      .q     (cell_q[i])
    );
  end

  assign top_car = cell_q[0];

endmodule

`default_nettype wire

>>> rtl/core/spc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequence controller: takes wanted cars, drives pushes and pops of the
// cell chain, counts positions and produces the yes/no result.
module spc_ctrl
  import spc_pkg::*;
#(
  parameter int MAX_CARS = DEF_MAX_CARS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [CAR_W-1:0] in_wanted_car,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic             out_feasible,
  input  wire logic [CAR_W-1:0] car_total,
  input  wire logic [CAR_W-1:0] top_car,
  output      spc_cmd_t         cmd,
  output      spc_stat_t        stat
);

  localparam int NCELLS  = spc_cells(MAX_CARS);
  localparam int DEPTH_W = $clog2(NCELLS + 1);

  typedef enum logic {
    S_IDLE,
    S_PUSH
  } state_t;

  state_t             state_r,        state_nxt;
  logic [CAR_W:0]     nte_r,          nte_nxt;
  logic [CAR_W-1:0]   target_r,       target_nxt;
  logic [DEPTH_W-1:0] depth_r,        depth_nxt;
  logic [CAR_W-1:0]   pos_r,          pos_nxt;
  logic               failed_r,       failed_nxt;
  logic               out_valid_r,    out_valid_nxt;
  logic               out_feasible_r, out_feasible_nxt;

  logic last_pos;
  logic out_free;
  logic accept;
  logic car_bad;
  logic car_new;
  logic need_push;
  logic top_match;
  logic fail_now;

  always_comb begin
    last_pos  = ({1'b0, pos_r} + (CAR_W + 1)'(1)) >= {1'b0, car_total};
    out_free  = !out_valid_r || out_ready;
    in_ready  = (state_r == S_IDLE) && (out_free || !last_pos);
    accept    = in_valid && in_ready;
    car_bad   = (in_wanted_car == '0) || (in_wanted_car > car_total);
    car_new   = {1'b0, in_wanted_car} >= nte_r;
    need_push = {1'b0, in_wanted_car} > nte_r;
    top_match = (depth_r != '0) && (top_car == (in_wanted_car - CAR_W'(1)));
    fail_now  = !failed_r && (car_bad || (!car_new && !top_match));
  end

  always_comb begin
    state_nxt        = state_r;
    nte_nxt          = nte_r;
    target_nxt       = target_r;
    depth_nxt        = depth_r;
    pos_nxt          = pos_r;
    failed_nxt       = failed_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_feasible_nxt = out_feasible_r;
    cmd              = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt    = pos_r + CAR_W'(1);
          failed_nxt = failed_r || fail_now;
          if (!failed_r && !car_bad) begin
            if (car_new) begin
              if (need_push && !last_pos) begin
                state_nxt  = S_PUSH;
                target_nxt = in_wanted_car;
              end else begin
                nte_nxt = {1'b0, in_wanted_car} + (CAR_W + 1)'(1);
              end
            end else if (top_match) begin
              cmd.pop   = 1'b1;
              depth_nxt = depth_r - DEPTH_W'(1);
            end
          end
          if (last_pos) begin
            out_valid_nxt    = 1'b1;
            out_feasible_nxt = !(failed_r || fail_now);
            nte_nxt          = (CAR_W + 1)'(1);
            depth_nxt        = '0;
            pos_nxt          = '0;
            failed_nxt       = 1'b0;
          end
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        cmd.data  = nte_r[CAR_W-1:0] - CAR_W'(1);
        depth_nxt = depth_r + DEPTH_W'(1);
        if ((nte_r + (CAR_W + 1)'(1)) == {1'b0, target_r}) begin
          nte_nxt   = {1'b0, target_r} + (CAR_W + 1)'(1);
          state_nxt = S_IDLE;
        end else begin
          nte_nxt = nte_r + (CAR_W + 1)'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nte_r       <= (CAR_W + 1)'(1);
      depth_r     <= '0;
      pos_r       <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      nte_r          <= nte_nxt;
      target_r       <= target_nxt;
      depth_r        <= depth_nxt;
      pos_r          <= pos_nxt;
      failed_r       <= failed_nxt;
      out_valid_r    <= out_valid_nxt;
      out_feasible_r <= out_feasible_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_feasible = out_feasible_r;
  assign stat.busy    = (state_r == S_PUSH);
  assign stat.empty   = (depth_r == '0);

endmodule

`default_nettype wire

>>> rtl/core/stack_permutation_checker.sv
// Stack permutation checker.
// Checks whether a wanted exit order of cars 1..n can be produced by running
// the cars, in order 1..n, through one holding stack. Each input transaction
// on in_valid/in_ready carries one wanted car (in_wanted_car). After the n-th
// transaction of a sequence, one result transaction on out_valid/out_ready
// reports out_feasible (1 = reachable), and the block clears for the next
// sequence. n comes from the car_count register, written through the
// cfg_valid/cfg_ready channel; 0 counts as 1 and values above MAX_CARS
// count as MAX_CARS. Cars of 0 or above n make the sequence infeasible.
// Latency: the result is valid the cycle after the last car is accepted.
// Flow: a car that needs no pushes does not hold off the next car; after a car
// that first pushes k smaller cars, input is held off while they are pushed,
// since the cell chain shifts one entry per cycle. Each car is pushed at most
// once per sequence.
// Reset (synchronous, rst_n low) sets car_count to 1 and empties the stack.
// When the receiver stalls, the result is held and further cars of the next
// sequence are still taken, up to the one that would produce a new result.
`timescale 1ns / 1ps
`default_nettype none

module stack_permutation_checker
  import spc_pkg::*;
#(
  parameter int MAX_CARS = DEF_MAX_CARS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CAR_W-1:0] cfg_car_count,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [CAR_W-1:0] in_wanted_car,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic             out_feasible
);

  `include "stack_permutation_checker_macros.svh"

  logic [CAR_W-1:0] car_count_r;
  logic [CAR_W-1:0] car_count_nxt;
  logic [CAR_W-1:0] car_total;
  logic [CAR_W-1:0] top_car;
  spc_cmd_t         cmd;
  spc_stat_t        stat;

  // The configuration register is always ready; the user must write it only while
  // the checker is idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  always_comb begin
    car_count_nxt = car_count_r;
    if (cfg_valid && cfg_ready) begin
      car_count_nxt = cfg_car_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_count_r <= CAR_W'(1);
    end else begin
      car_count_r <= car_count_nxt;
    end
  end

  // Clamp the programmed count into the range the stack can serve.
  always_comb begin
    if (car_count_r == '0) begin
      car_total = CAR_W'(1);
    end else if (32'(car_count_r) > 32'(MAX_CARS)) begin
      car_total = CAR_W'(MAX_CARS);
    end else begin
      car_total = car_count_r;
    end
  end

  spc_ctrl #(
    .MAX_CARS (MAX_CARS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_wanted_car (in_wanted_car),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_feasible  (out_feasible),
    .car_total     (car_total),
    .top_car       (top_car),
    .cmd           (cmd),
    .stat          (stat)
  );

  spc_stack #(
    .MAX_CARS (MAX_CARS)
  ) u_stack (
    .clk     (clk),
    .cmd     (cmd),
    .top_car (top_car)
  );

  // A new result only appears right after an input transaction.
  `SPC_ASSERT_NOW(a_result_from_input, out_valid && !$past(out_valid), $past(in_valid && in_ready), "result raised without an accepted car")

  // No car is taken while smaller cars are still being pushed.
  `SPC_ASSERT_NOW(a_no_take_while_push, stat.busy, !in_ready, "input accepted during push sequence")

  // A push always leaves at least one car in the stack.
  `SPC_ASSERT_NEXT(a_push_fills, cmd.push, !stat.empty, "stack empty after a push")

endmodule

`default_nettype wire

>>> dv/tb_stack_permutation_checker.sv
`timescale 1ns / 1ps

module tb_stack_permutation_checker;
  import spc_pkg::*;

  localparam int MAX_CARS    = DEF_MAX_CARS;
  localparam int SLOT_W      = $clog2(MAX_CARS);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_CARS = 2000;
  // A car that pushes smaller cars keeps the cell chain busy while it pushes
  // them, without producing a result, so a register write that follows a car
  // with no result waits out the longest possible push run first.
  localparam int PUSH_HOLD   = MAX_CARS + 16;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             cfg_valid     = 1'b0;
  logic             cfg_ready;
  logic [CAR_W-1:0] cfg_car_count = '0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [CAR_W-1:0] in_wanted_car = '0;
  logic             out_valid;
  logic             out_ready     = 1'b1;
  logic             out_feasible;

  stack_permutation_checker #(
    .MAX_CARS(MAX_CARS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_car_count(cfg_car_count),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_wanted_car(in_wanted_car),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_feasible (out_feasible)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block: the configured count as written, the next car
  // that has not yet entered the siding, the siding itself (car number minus
  // one per slot), how many cars of the current train were taken, and whether
  // the train is already known to be impossible.
  logic [CAR_W-1:0]  count_reg = 1;
  logic [CAR_W-1:0]  next_arrival;
  logic [SLOT_W-1:0] siding [MAX_CARS];
  logic [CAR_W-1:0]  siding_top;
  logic [CAR_W-1:0]  cars_seen;
  logic              seq_bad;

  // Verdicts still owed by the block, oldest first.
  logic              verdict_q [$];
  logic              verdict_exp;

  logic [CAR_W-1:0]  car_order [$];
  int unsigned       cars_sent   = 0;
  int unsigned       mismatches  = 0;
  int unsigned       cycle_count = 0;

  // Sender burst control and the receiver's ready pattern.
  bit                sender_bursty = 1'b0;
  int unsigned       burst_left    = 0;
  logic [7:0]        stall_pattern = 8'hFF;
  logic [2:0]        stall_phase   = '0;

  // A count of zero behaves as one car, and anything past the siding
  // capacity behaves as the capacity.
  function automatic logic [CAR_W-1:0] train_length(input logic [CAR_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_CARS) return CAR_W'(MAX_CARS);
    return raw;
  endfunction

  task automatic clear_train();
    next_arrival = 1;
    siding_top   = 0;
    cars_seen    = 0;
    seq_bad      = 1'b0;
  endtask

  // Advances the shadow copy by one accepted car and queues a verdict when
  // the train is complete.
  task automatic route_car(input logic [CAR_W-1:0] car);
    logic [CAR_W-1:0] n;
    n = train_length(count_reg);
    if (!seq_bad) begin
      if (car < 1 || car > n) begin
        seq_bad = 1'b1;
      end else if (car >= next_arrival) begin
        // Every smaller car that has not entered goes into the siding, and
        // the wanted car runs straight through.
        while (next_arrival < car && siding_top < MAX_CARS) begin
          siding[siding_top] = SLOT_W'(next_arrival - 1);
          siding_top++;
          next_arrival++;
        end
        if (next_arrival < car) begin
          seq_bad = 1'b1;
        end else begin
          next_arrival = car + CAR_W'(1);
        end
      end else if (siding_top != 0 && siding[siding_top - 1] == SLOT_W'(car - 1)) begin
        siding_top--;
      end else begin
        // The car already entered but is buried below the top of the siding.
        seq_bad = 1'b1;
      end
    end
    cars_seen++;
    // A count lowered in the middle of a train ends it as soon as the number
    // of cars taken reaches or passes the new count.
    if (cars_seen >= n) begin
      verdict_q.push_back(!seq_bad);
      clear_train();
    end
  endtask

  // Offers one car and waits for the transaction. In bursty mode the sender
  // drops valid between bursts; the drop always precedes a
  // wait, so valid is never lowered and raised in the same time step.
  task automatic send_car(input logic [CAR_W-1:0] car);
    if (sender_bursty && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid      <= 1'b1;
    in_wanted_car <= car;
    do @(posedge clk); while (!in_ready);
    if (burst_left != 0) burst_left--;
    cars_sent++;
    route_car(car);
  endtask

  // Stops offering cars and waits until every owed verdict has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  // Register writes only happen with the block idle. If the last car did not
  // finish a train, the block may still be pushing, so hold off first.
  task automatic write_car_count(input logic [CAR_W-1:0] value);
    wait_results_drained();
    if (cars_seen != 0) repeat (PUSH_HOLD) @(posedge clk);
    cfg_car_count <= value;
    cfg_valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_reg = value;
  endtask

  // Builds a random order that one siding can always produce: at each step
  // either the next car enters or the top car leaves.
  task automatic build_stack_order(input int unsigned n);
    int unsigned held [$];
    int unsigned upcoming;
    car_order.delete();
    upcoming = 1;
    while (car_order.size() < n) begin
      if (upcoming <= n && (held.size() == 0 || $urandom_range(0, 1) == 1)) begin
        held.push_back(upcoming);
        upcoming++;
      end else begin
        car_order.push_back(CAR_W'(held.pop_back()));
      end
    end
  endtask

  // Right after reset the count is one, so every car gives a verdict. Zero
  // and the all-ones code are out of range, as is any car above one.
  task automatic test_after_reset();
    sender_bursty = 1'b0;
    stall_pattern <= 8'hFF;
    send_car(1);
    send_car(0);
    send_car(CAR_W'(CAR_MAX_CODE));
    send_car(2);
  endtask

  // Three-car trains: a full reversal, a car buried in the siding, the plain
  // order, a repeated car, and an out-of-range car followed by a car that must
  // be ignored once the train has failed.
  task automatic test_stack_orders();
    logic [CAR_W-1:0] orders [15] = '{3, 2, 1,  3, 1, 2,  1, 2, 3,
                                      2, 2, 1,  1, CAR_W'(CAR_MAX_CODE), 3};
    write_car_count(3);
    sender_bursty = 1'b1;
    stall_pattern <= 8'b0101_1011;
    foreach (orders[i]) send_car(orders[i]);
  endtask

  // A count of zero, a count far above the capacity with the largest car,
  // and counts lowered partway through a train, both failing and passing.
  task automatic test_count_limits();
    write_car_count(0);
    send_car(1);
    write_car_count(CAR_W'(CAR_MAX_CODE));
    send_car(CAR_W'(MAX_CARS));
    send_car(CAR_W'(MAX_CARS - 1));
    write_car_count(2);
    send_car(2);
    write_car_count(5);
    send_car(1);
    send_car(2);
    write_car_count(3);
    send_car(3);
  endtask

  // Mostly trains the siding can produce, with random content, plus trains
  // with two cars swapped, a stray car, or pure noise. Counts are mostly
  // small, sometimes one or zero, now and then 65 to 300.
  task automatic test_random_traffic();
    int unsigned      first_sent;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      a;
    int unsigned      b;
    logic [CAR_W-1:0] raw;
    logic [CAR_W-1:0] swap;
    first_sent = cars_sent;
    while (cars_sent - first_sent < RANDOM_CARS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) raw = 1;
      else if (pick == 1) raw = 0;
      else if (pick == 2) raw = CAR_W'($urandom_range(65, 300));
      else raw = CAR_W'($urandom_range(2, 24));
      write_car_count(raw);
      n = train_length(raw);
      sender_bursty = ($urandom_range(0, 3) != 0);
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      repeat (120 / n + 1) begin
        build_stack_order(n);
        pick = $urandom_range(0, 9);
        a    = $urandom_range(0, n - 1);
        b    = $urandom_range(0, n - 1);
        if (pick == 6 || pick == 7) begin
          swap         = car_order[a];
          car_order[a] = car_order[b];
          car_order[b] = swap;
        end else if (pick == 8) begin
          car_order[a] = CAR_W'($urandom_range(0, CAR_MAX_CODE));
        end else if (pick == 9) begin
          foreach (car_order[i]) car_order[i] = CAR_W'($urandom_range(0, n + 1));
        end
        foreach (car_order[i]) send_car(car_order[i]);
        // Now and then the sender waits until every verdict is back.
        if ($urandom_range(0, 15) == 0) wait_results_drained();
      end
      // Sometimes leave a train half done so the next count change lands
      // in the middle of it.
      if (n > 1 && $urandom_range(0, 4) == 0) begin
        build_stack_order(n);
        repeat ($urandom_range(1, n - 1)) send_car(car_order.pop_front());
      end
    end
  endtask

  // The receiver follows an 8-bit ready pattern, one bit picked by each phase.
  always @(posedge clk) begin
    out_ready   <= stall_pattern[stall_phase];
    stall_phase <= stall_phase + 3'd1;
  end

  // Each result transaction is matched against the oldest owed verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got feasible=%0b",
                 $time, out_feasible);
      end else begin
        verdict_exp = verdict_q.pop_front();
        if (out_feasible !== verdict_exp) begin
          mismatches++;
          $display("%0t: feasible mismatch, expected %0b, got %0b",
                   $time, verdict_exp, out_feasible);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_stack_permutation_checker: done, errors");
      $finish;
    end
  end

  initial begin
    clear_train();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_stack_orders();
    test_count_limits();
    test_random_traffic();
    wait_results_drained();
    // A tail after the last verdict catches any stray result
    // transaction.
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_stack_permutation_checker: done, clean");
    end else begin
      $display("tb_stack_permutation_checker: done, errors");
    end
    $finish;
  end

endmodule
